// File: sv/tsr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsr_pkg: shared types and constants of the three-shear pixel rotator
// Widths of the fixed-point datapath, register codes and the rounding helper.
// ----------------------------------------------------------------------------
package tsr_pkg;

    localparam int COORD_W   = 12;   // source and destination coordinates
    localparam int DIM_W     = 13;   // image width and height registers
    localparam int COEF_W    = 18;   // signed Q1.16 coefficients
    localparam int PIX_W     = 32;   // pixel word on the channels
    localparam int Q_FRAC    = 16;   // fraction bits of the coefficients
    localparam int SUM_W     = 36;   // exact Q16 sum of every shear
    localparam int CFG_IDX_W = 2;

    // Centered coordinates and the result of each shear
    localparam int XY_W = 13;        // src - center
    localparam int X1_W = 15;        // shear one result
    localparam int Y1_W = 16;        // shear two result
    localparam int X2_W = 18;        // shear three result

    localparam int DEF_MAX_DIM    = 4096;
    localparam int DEF_PIXEL_BITS = 32;

    localparam logic [DIM_W-1:0] RST_WIDTH  = 13'd1024;
    localparam logic [DIM_W-1:0] RST_HEIGHT = 13'd1024;

    localparam logic [CFG_IDX_W-1:0] REG_TAN_HALF = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIN      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 2'd3;

    localparam logic signed [SUM_W-1:0] RND_POS = 36'sd32768;
    localparam logic signed [SUM_W-1:0] RND_NEG = 36'sd32767;

    typedef struct packed {
        logic signed [COEF_W-1:0] tan_half;
        logic signed [COEF_W-1:0] sin_val;
        logic [DIM_W-1:0]         width;    // clamped to the maximum dimension
        logic [DIM_W-1:0]         height;
        logic [COORD_W-1:0]       cx;
        logic [COORD_W-1:0]       cy;
    } t_cfg;

    // Q16 to integer, ties away from zero
    function automatic logic signed [SUM_W-1:0] round_q16(
        input logic signed [SUM_W-1:0] num
    );
        logic signed [SUM_W-1:0] bias;
        bias = num[SUM_W-1] ? RND_NEG : RND_POS;
        return (num + bias) >>> Q_FRAC;
    endfunction

endpackage

`default_nettype wire

// File: sv/tsr_ifs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsr_ifs: channel interfaces of the three-shear pixel rotator
// Source pixel channel, destination pixel channel and register write channel.
// ----------------------------------------------------------------------------
interface tsr_in_if;
    logic                        valid;
    logic                        ready;
    logic [tsr_pkg::COORD_W-1:0] src_x;
    logic [tsr_pkg::COORD_W-1:0] src_y;
    logic [tsr_pkg::PIX_W-1:0]   src_pixel;

    modport source (output valid, output src_x, output src_y, output src_pixel,
                    input ready);
    modport sink   (input valid, input src_x, input src_y, input src_pixel,
                    output ready);
endinterface

interface tsr_out_if;
    logic                        valid;
    logic                        ready;
    logic [tsr_pkg::COORD_W-1:0] dst_x;
    logic [tsr_pkg::COORD_W-1:0] dst_y;
    logic [tsr_pkg::PIX_W-1:0]   dst_pixel;

    modport source (output valid, output dst_x, output dst_y, output dst_pixel,
                    input ready);
    modport sink   (input valid, input dst_x, input dst_y, input dst_pixel,
                    output ready);
endinterface

interface tsr_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [tsr_pkg::CFG_IDX_W-1:0] index;
    logic [tsr_pkg::COEF_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: sv/three_shear_pixel_rotator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// three_shear_pixel_rotator: forward-maps pixels through three shears
// Rotates each source pixel about the image center by x-y-x shears.
// ----------------------------------------------------------------------------
// Usage:
//   i_in   carries one request per pixel: src_x, src_y and src_pixel.
//   o_out  returns dst_x, dst_y and dst_pixel for every pixel whose rotated
//          position lies inside the image; other pixels are dropped silently.
//   i_cfg  writes tan(angle/2), sin(angle) (signed Q1.16), width, height.
//          Write it only while no pixel is in flight; it is always ready.
// Throughput: one request per clock, with no bubbles, while o_out.ready is held.
// Pipeline: 8 register stages: one centering stage, two stages per shear
//   (multiply, then round) and the bound-check output stage.
// Reset clears all stage valid bits and loads tan = sin = 0 and a
//   1024 x 1024 image. When the receiver stalls, each stage holds as long
//   as the stage after it is full; i_in.ready drops once every stage is
//   occupied, so no request is lost or repeated.
// ----------------------------------------------------------------------------
module three_shear_pixel_rotator #(
    parameter int MAX_DIM    = tsr_pkg::DEF_MAX_DIM,
    parameter int PIXEL_BITS = tsr_pkg::DEF_PIXEL_BITS
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    tsr_in_if.sink    i_in,
    tsr_cfg_if.sink   i_cfg,
    tsr_out_if.source o_out
);
    import tsr_pkg::*;

    localparam logic [PIX_W-1:0] PIX_MASK = (PIXEL_BITS >= PIX_W) ? {PIX_W{1'b1}}
        : PIX_W'((64'd1 << PIXEL_BITS) - 64'd1);

    t_cfg cfg;

    // centering stage
    logic                   r_cv;
    logic signed [XY_W-1:0] r_x;
    logic signed [XY_W-1:0] r_y;
    logic [PIX_W-1:0]       r_pix;
    logic                   c_ready;

    // shear one: x1 = round(x - y * T)
    logic                   s1_ready;
    logic                   s1_valid;
    logic signed [X1_W-1:0] s1_x1;
    logic signed [XY_W-1:0] s1_y;
    logic [PIX_W-1:0]       s1_pix;

    // shear two: y1 = round(y + x1 * S)
    logic                   s2_ready;
    logic                   s2_valid;
    logic signed [Y1_W-1:0] s2_y1;
    logic signed [X1_W-1:0] s2_x1;
    logic [PIX_W-1:0]       s2_pix;

    // shear three: x2 = round(x1 - y1 * T)
    logic                   s3_ready;
    logic                   s3_valid;
    logic signed [X2_W-1:0] s3_x2;
    logic signed [Y1_W-1:0] s3_y1;
    logic [PIX_W-1:0]       s3_pix;

    logic                   out_ready;

    tsr_cfg #(
        .MAX_DIM (MAX_DIM)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    // Shift the source point to center-relative coordinates
    assign c_ready    = !r_cv || s1_ready;
    assign i_in.ready = c_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv <= 1'b0;
        end else if (c_ready) begin
            r_cv <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_ready && i_in.valid) begin
            r_x   <= $signed({1'b0, i_in.src_x}) - $signed({1'b0, cfg.cx});
            r_y   <= $signed({1'b0, i_in.src_y}) - $signed({1'b0, cfg.cy});
            r_pix <= i_in.src_pixel & PIX_MASK;
        end
    end

    tsr_shear #(
        .A_W      (XY_W),
        .B_W      (XY_W),
        .R_W      (X1_W),
        .SIDE_W   (PIX_W),
        .SUBTRACT (1'b1)
    ) u_shear1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_cv),
        .o_ready (s1_ready),
        .i_a     (r_x),
        .i_b     (r_y),
        .i_side  (r_pix),
        .i_coef  (cfg.tan_half),
        .o_valid (s1_valid),
        .i_ready (s2_ready),
        .o_res   (s1_x1),
        .o_b     (s1_y),
        .o_side  (s1_pix)
    );

    tsr_shear #(
        .A_W      (XY_W),
        .B_W      (X1_W),
        .R_W      (Y1_W),
        .SIDE_W   (PIX_W),
        .SUBTRACT (1'b0)
    ) u_shear2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .o_ready (s2_ready),
        .i_a     (s1_y),
        .i_b     (s1_x1),
        .i_side  (s1_pix),
        .i_coef  (cfg.sin_val),
        .o_valid (s2_valid),
        .i_ready (s3_ready),
        .o_res   (s2_y1),
        .o_b     (s2_x1),
        .o_side  (s2_pix)
    );

    tsr_shear #(
        .A_W      (X1_W),
        .B_W      (Y1_W),
        .R_W      (X2_W),
        .SIDE_W   (PIX_W),
        .SUBTRACT (1'b1)
    ) u_shear3 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s2_valid),
        .o_ready (s3_ready),
        .i_a     (s2_x1),
        .i_b     (s2_y1),
        .i_side  (s2_pix),
        .i_coef  (cfg.tan_half),
        .o_valid (s3_valid),
        .i_ready (out_ready),
        .o_res   (s3_x2),
        .o_b     (s3_y1),
        .o_side  (s3_pix)
    );

    // Drop points that land outside the image, hold the rest for the sink
    tsr_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s3_valid),
        .o_ready (out_ready),
        .i_x2    (s3_x2),
        .i_y1    (s3_y1),
        .i_pixel (s3_pix),
        .i_cfg   (cfg),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

// File: sv/tsr_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsr_cfg: register file of the rotator
// Holds coefficients and image size; clamps the size and derives the center.
// ----------------------------------------------------------------------------
module tsr_cfg #(
    parameter int MAX_DIM = tsr_pkg::DEF_MAX_DIM
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    tsr_cfg_if.sink      i_cfg,
    output tsr_pkg::t_cfg o_cfg
);
    import tsr_pkg::*;

    logic signed [COEF_W-1:0] r_tan_half;
    logic signed [COEF_W-1:0] r_sin;
    logic [DIM_W-1:0]         r_width;
    logic [DIM_W-1:0]         r_height;
    logic [DIM_W-1:0]         w_clamp;
    logic [DIM_W-1:0]         h_clamp;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tan_half <= '0;
            r_sin      <= '0;
            r_width    <= RST_WIDTH;
            r_height   <= RST_HEIGHT;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_TAN_HALF: r_tan_half <= $signed(i_cfg.data);
                REG_SIN:      r_sin      <= $signed(i_cfg.data);
                REG_WIDTH:    r_width    <= i_cfg.data[DIM_W-1:0];
                REG_HEIGHT:   r_height   <= i_cfg.data[DIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // saturate oversized dimensions
    assign w_clamp = (32'(r_width) > 32'(MAX_DIM))  ? DIM_W'(MAX_DIM) : r_width;
    assign h_clamp = (32'(r_height) > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM) : r_height;

    always_comb begin
        o_cfg.tan_half = r_tan_half;
        o_cfg.sin_val  = r_sin;
        o_cfg.width    = w_clamp;
        o_cfg.height   = h_clamp;
        o_cfg.cx       = w_clamp[DIM_W-1:1];
        o_cfg.cy       = h_clamp[DIM_W-1:1];
    end

endmodule

`default_nettype wire

// File: sv/tsr_shear.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsr_shear: one shear step, two pipeline stages
// Stage one registers b * coef; stage two rounds a * 2^16 +/- product.
// ----------------------------------------------------------------------------
module tsr_shear #(
    parameter int A_W  = 13,
    parameter int B_W  = 13,
    parameter int R_W  = 15,
    parameter int SIDE_W = 32,
    parameter bit SUBTRACT = 1'b1
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output      logic                       o_ready,
    input  wire logic signed [A_W-1:0]      i_a,
    input  wire logic signed [B_W-1:0]      i_b,
    input  wire logic [SIDE_W-1:0]          i_side,
    input  wire logic signed [tsr_pkg::COEF_W-1:0] i_coef,
    output      logic                       o_valid,
    input  wire logic                       i_ready,
    output      logic signed [R_W-1:0]      o_res,
    output      logic signed [B_W-1:0]      o_b,
    output      logic [SIDE_W-1:0]          o_side
);
    import tsr_pkg::*;

    localparam int P_W = B_W + COEF_W;

    // product stage
    logic                    r_pv;
    logic signed [P_W-1:0]   r_prod;
    logic signed [A_W-1:0]   r_pa;
    logic signed [B_W-1:0]   r_pb;
    logic [SIDE_W-1:0]       r_pside;
    logic signed [P_W-1:0]   n_prod;
    logic                    p_ready;

    // rounding stage
    logic                    r_rv;
    logic signed [R_W-1:0]   r_res;
    logic signed [B_W-1:0]   r_rb;
    logic [SIDE_W-1:0]       r_rside;
    logic                    r_ready;
    logic signed [SUM_W-1:0] a_q;
    logic signed [SUM_W-1:0] num;
    logic signed [SUM_W-1:0] n_res;

    assign r_ready = !r_rv || i_ready;
    assign p_ready = !r_pv || r_ready;
    assign o_ready = p_ready;

    assign n_prod = i_b * i_coef;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else if (p_ready) begin
            r_pv <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (p_ready && i_valid) begin
            r_prod  <= n_prod;
            r_pa    <= i_a;
            r_pb    <= i_b;
            r_pside <= i_side;
        end
    end

    assign a_q   = SUM_W'(r_pa) <<< Q_FRAC;
    assign num   = SUBTRACT ? (a_q - SUM_W'(r_prod)) : (a_q + SUM_W'(r_prod));
    assign n_res = round_q16(num);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rv <= 1'b0;
        end else if (r_ready) begin
            r_rv <= r_pv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_ready && r_pv) begin
            r_res   <= n_res[R_W-1:0];
            r_rb    <= r_pb;
            r_rside <= r_pside;
        end
    end

    assign o_valid = r_rv;
    assign o_res   = r_res;
    assign o_b     = r_rb;
    assign o_side  = r_rside;

endmodule

`default_nettype wire

// File: sv/tsr_out.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsr_out: destination bound check and output register
// Moves the rotated point back to image coordinates; drops points outside.
// ----------------------------------------------------------------------------
module tsr_out (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output      logic                                o_ready,
    input  wire logic signed [tsr_pkg::X2_W-1:0]     i_x2,
    input  wire logic signed [tsr_pkg::Y1_W-1:0]     i_y1,
    input  wire logic [tsr_pkg::PIX_W-1:0]           i_pixel,
    input  wire tsr_pkg::t_cfg                       i_cfg,
    tsr_out_if.source                                o_out
);
    import tsr_pkg::*;

    localparam int DX_W = X2_W + 1;
    localparam int DY_W = Y1_W + 1;

    logic                  r_valid;
    logic [COORD_W-1:0]    r_dx;
    logic [COORD_W-1:0]    r_dy;
    logic [PIX_W-1:0]      r_pix;
    logic signed [DX_W-1:0] dx;
    logic signed [DY_W-1:0] dy;
    logic                  inb;
    logic                  load;

    assign dx = DX_W'(i_x2) + DX_W'($signed({1'b0, i_cfg.cx}));
    assign dy = DY_W'(i_y1) + DY_W'($signed({1'b0, i_cfg.cy}));

    assign inb = !dx[DX_W-1] && (dx < DX_W'($signed({1'b0, i_cfg.width})))
              && !dy[DY_W-1] && (dy < DY_W'($signed({1'b0, i_cfg.height})));

    assign load    = !r_valid || o_out.ready;
    assign o_ready = load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_valid && inb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_valid) begin
            r_dx  <= dx[COORD_W-1:0];
            r_dy  <= dy[COORD_W-1:0];
            r_pix <= i_pixel;
        end
    end

    assign o_out.valid     = r_valid;
    assign o_out.dst_x     = r_dx;
    assign o_out.dst_y     = r_dy;
    assign o_out.dst_pixel = r_pix;

endmodule

`default_nettype wire
